@@ src/srfp_pkg.sv @@
// ----------------------------------------------------------------------------
// srfp_pkg: shared types and constants
// Frame bytes, frame phase encoding, config register indexes and the
// structs passed between the frame parser modules.
// ----------------------------------------------------------------------------
package srfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] TRAIL_CR    = 8'h0D;
	localparam logic [7:0] TRAIL_LF    = 8'h0A;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned STAMP_W = 64;
	localparam int unsigned CFG_IDX_W = 8;

	// Input tdata: rx_byte, arrival_time
	localparam int unsigned IN_DATA_W  = BYTE_W + STAMP_W;
	// Output tdata: request_code, request_page, frame_start_time
	localparam int unsigned OUT_DATA_W = 2 * BYTE_W + STAMP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CODE_MEASURE = 8'd0,
		REG_CODE_CACHE   = 8'd1,
		REG_CODE_ABORT   = 8'd2,
		REG_PAGE_TIME    = 8'd3,
		REG_PAGE_FREQ    = 8'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_CMD   = 3'd2,
		PH_PAGE  = 3'd3,
		PH_CR    = 3'd4,
		PH_LF    = 3'd5
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] code_measure;
		logic [BYTE_W-1:0] code_cache;
		logic [BYTE_W-1:0] code_abort;
		logic [BYTE_W-1:0] page_time_code;
		logic [BYTE_W-1:0] page_freq_code;
	} cfg_t;

	typedef struct packed {
		logic               emit;
		logic [BYTE_W-1:0]  request_code;
		logic [BYTE_W-1:0]  request_page;
		logic [STAMP_W-1:0] frame_start_time;
	} parse_res_t;

endpackage

@@ src/srfp_cfg.sv @@
// ----------------------------------------------------------------------------
// srfp_cfg: request and page code registers
// Holds the five match codes; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module srfp_cfg
	import srfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [BYTE_W-1:0]    wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_measure   <= 8'd1;
			cfg_q.code_cache     <= 8'd2;
			cfg_q.code_abort     <= 8'd3;
			cfg_q.page_time_code <= 8'd0;
			cfg_q.page_freq_code <= 8'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CODE_MEASURE: cfg_q.code_measure   <= wr_data;
				REG_CODE_CACHE:   cfg_q.code_cache     <= wr_data;
				REG_CODE_ABORT:   cfg_q.code_abort     <= wr_data;
				REG_PAGE_TIME:    cfg_q.page_time_code <= wr_data;
				REG_PAGE_FREQ:    cfg_q.page_freq_code <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/srfp_parse.sv @@
// ----------------------------------------------------------------------------
// srfp_parse: frame phase tracker and request filter
// Walks the six-byte frame one byte per advance and flags a result when a
// frame ends with matching command and page codes.
// ----------------------------------------------------------------------------
module srfp_parse
	import srfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [BYTE_W-1:0]  rx_byte,
	input  logic [STAMP_W-1:0] arrival_time,
	input  cfg_t               cfg,
	output parse_res_t         res
);

	phase_t             phase_q;
	phase_t             phase_nxt;
	logic [BYTE_W-1:0]  held_command_q;
	logic [BYTE_W-1:0]  held_page_q;
	logic [STAMP_W-1:0] start_stamp_q;

	logic cmd_ok;
	logic page_ok;
	logic take_stamp;
	logic take_cmd;
	logic take_page;
	logic emit;

	assign cmd_ok  = (held_command_q == cfg.code_measure) ||
	                 (held_command_q == cfg.code_cache) ||
	                 (held_command_q == cfg.code_abort);
	assign page_ok = (held_page_q == cfg.page_time_code) ||
	                 (held_page_q == cfg.page_freq_code);

	// Next phase
	always_comb begin
		phase_nxt = PH_HUNT;
		unique case (phase_q)
			PH_HUNT: begin
				phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
			end
			PH_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_nxt = PH_CMD;
				end else if (rx_byte == SYNC_FIRST) begin
					phase_nxt = PH_SYNC2;
				end
			end
			PH_CMD:  phase_nxt = PH_PAGE;
			PH_PAGE: phase_nxt = PH_CR;
			PH_CR: begin
				if (rx_byte == TRAIL_CR) begin
					phase_nxt = PH_LF;
				end else if (rx_byte == SYNC_FIRST) begin
					phase_nxt = PH_SYNC2;
				end
			end
			default: begin
				// trailer slot; an unexpected sync byte reopens a frame
				phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
			end
		endcase
	end

	// Captures and result flag
	always_comb begin
		take_stamp = 1'b0;
		take_cmd   = 1'b0;
		take_page  = 1'b0;
		emit       = 1'b0;
		unique case (phase_q)
			PH_HUNT, PH_SYNC2, PH_CR: take_stamp = (rx_byte == SYNC_FIRST);
			PH_CMD:  take_cmd  = 1'b1;
			PH_PAGE: take_page = 1'b1;
			default: begin
				emit       = (rx_byte == TRAIL_LF) && cmd_ok && page_ok;
				take_stamp = (rx_byte == SYNC_FIRST);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			held_command_q <= '0;
			held_page_q    <= '0;
			start_stamp_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			if (take_cmd) begin
				held_command_q <= rx_byte;
			end
			if (take_page) begin
				held_page_q <= rx_byte;
			end
			if (take_stamp) begin
				start_stamp_q <= arrival_time;
			end
		end
	end

	assign res.emit             = emit;
	assign res.request_code     = held_command_q;
	assign res.request_page     = held_page_q;
	assign res.frame_start_time = start_stamp_q;

endmodule

@@ src/serial_request_frame_parser.sv @@
// ----------------------------------------------------------------------------
// serial_request_frame_parser: request frame recognizer for a serial link
// Path: a closing byte is staged in the input register, then its result loads the result register that drives m_tdata.
// Throughput: one byte per cycle, except while a result waits for a stalled output.
// A stalled output holds one result; bytes keep flowing until the next closing byte
// that yields a result, which waits in the input register until the output drains.
// Reset: arst_n clears the phase to hunting, both register stages to empty, codes to defaults.
// ----------------------------------------------------------------------------
module serial_request_frame_parser
	import srfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Byte input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte, [71:8] arrival_time
	// Request output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] request_code, [15:8] request_page,
	                                         // [79:16] frame_start_time
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]     cfg_data
);

	cfg_t       cfg;
	parse_res_t res;

	// Input register stage
	logic               valid_s1;
	logic [BYTE_W-1:0]  rx_byte_s1;
	logic [STAMP_W-1:0] arrival_time_s1;
	logic               consume_s1;

	// Result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Registers are always writable; the sender must keep the stream idle during writes (not enforced here).
	assign cfg_ready = 1'b1;

	srfp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Retire the staged byte unless it produces a result that has nowhere to go.
	assign consume_s1 = valid_s1 && (!res.emit || !out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || consume_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload: load on every input transaction, no reset needed.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1      <= s_tdata[BYTE_W-1:0];
			arrival_time_s1 <= s_tdata[IN_DATA_W-1:BYTE_W];
		end
	end

	srfp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (consume_s1),
		.rx_byte      (rx_byte_s1),
		.arrival_time (arrival_time_s1),
		.cfg          (cfg),
		.res          (res)
	);

	// Result register: load an accepted frame, drop the flag once the
	// downstream transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume_s1 && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1 && res.emit) begin
			out_data_q <= {res.frame_start_time, res.request_page, res.request_code};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A full input stage never reports ready unless it drains this cycle.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && valid_s1 && !consume_s1))
		else $error("input stage overrun");

	// A frame result that reaches the output is presented next cycle.
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(consume_s1 && res.emit) |=> m_tvalid)
		else $error("accepted frame not presented");

	// A result blocked by a stalled output keeps its closing byte staged.
	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res.emit && out_valid_q && !m_tready) |=> valid_s1)
		else $error("blocked frame byte lost");

endmodule
